// ===== rtl/core/rba_pkg.sv =====
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types and constants of the ring buffer allocator.
// ----------------------------------------------------------------------------
package rba_pkg;

    localparam int RBA_ADDR_BITS     = 24;
    localparam int RBA_PENDING_DEPTH = 16;
    localparam logic [3:0] RBA_ALIGN_RESET = 4'd8;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // configuration register indexes
    localparam logic CFG_REGION = 1'b0;
    localparam logic CFG_ALIGN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_ROUND,
        S_AL_SUM,
        S_AL_CHECK,
        S_AL_WRAP,
        S_AL_WRAP2,
        S_AL_COMMIT,
        S_OLD_A,
        S_OLD_B,
        S_HEAD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } rba_state_t;

endpackage

// ===== rtl/core/ring_buffer_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_allocator_unit
// Allocates aligned blocks from a circular region; frees retire in order.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one transfer per request, and each
// request produces exactly one response transfer on m_axis.
// Configuration (region size, alignment) is written through cfg_wr_en /
// cfg_addr / cfg_wdata while no request is in flight.
// An allocate rounds the offset and size up, sums them and checks for space;
// a refusal then goes to the response register, a grant is committed first,
// and one that would pass the region end wraps to offset 0 and is checked
// again. A pointer reset or no-op goes straight to the response register.
// A free first resolves the head, then makes one pass over the pending table
// per retirement, recomputing the oldest start and visiting the slots in
// order, reading and comparing each occupied one; after the last pass the
// response is loaded. The pending table is scanned one slot at a time.
// One request is worked on at a time.
// The response sits in an output register, so a new request is accepted
// while the previous response waits; if the receiver stalls, the block
// holds in its final state until the output register frees up.
// Reset clears pointers, used length, skip length and all pending valid
// bits; pending memory contents are not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_allocator_unit #(
    parameter int ADDR_BITS     = rba_pkg::RBA_ADDR_BITS,
    parameter int PENDING_DEPTH = rba_pkg::RBA_PENDING_DEPTH,
    localparam int FIELDS_W     = 3 * ADDR_BITS + 4,
    localparam int DATA_W       = ((FIELDS_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // op, req_size, free_offset, free_size (from bit 0 up)
    input  logic [DATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status, alloc_offset, alloc_size, space_left (from bit 0 up)
    output logic [DATA_W-1:0] m_axis_tdata,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [ADDR_BITS:0] cfg_wdata
);

    localparam int W  = (ADDR_BITS + 4 > 18) ? ADDR_BITS + 4 : 18;
    localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int SZ = ADDR_BITS + 1;
    localparam int ENT_W = SZ + ADDR_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(PENDING_DEPTH - 1);

    function automatic logic [W-1:0] round_up(input logic [W-1:0] x,
                                              input logic [3:0] al);
        logic [W-1:0] m;
        m = (W'(1) << al) - W'(1);
        return (x + m) & ~m;
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a,
                                             input logic [W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    // input fields
    logic [1:0]           in_op;
    logic [SZ-1:0]        in_req;
    logic [ADDR_BITS-1:0] in_foff;
    logic [SZ-1:0]        in_fsize;
    assign in_op    = s_axis_tdata[1:0];
    assign in_req   = s_axis_tdata[SZ+1:2];
    assign in_foff  = s_axis_tdata[SZ+ADDR_BITS+1:SZ+2];
    assign in_fsize = s_axis_tdata[2*SZ+ADDR_BITS+1:SZ+ADDR_BITS+2];

    rba_pkg::rba_state_t state_reg, state_next;

    logic [SZ-1:0]        region_reg;
    logic [3:0]           align_reg;
    logic [SZ-1:0]        req_reg, req_next;
    logic [ADDR_BITS-1:0] foff_reg, foff_next;
    logic [SZ-1:0]        fsize_reg, fsize_next;
    logic [W-1:0]         wo_reg, wo_next;
    logic [W-1:0]         used_reg, used_next;
    logic [W-1:0]         eskip_reg, eskip_next;
    logic [W-1:0]         wp_reg, wp_next;
    logic [W-1:0]         bytes_reg, bytes_next;
    logic [W-1:0]         inc_reg, inc_next;
    logic [W-1:0]         end_reg, end_next;
    logic                 wrapped_reg, wrapped_next;
    logic [W-1:0]         internal_reg, internal_next;
    logic [W-1:0]         actual_reg, actual_next;
    logic [W-1:0]         skip_reg, skip_next;
    logic                 skipd_reg, skipd_next;
    logic                 head_reg, head_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] res_off_reg, res_off_next;
    logic [SZ-1:0]        res_size_reg, res_size_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [PENDING_DEPTH-1:0] valid_reg, valid_next;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_data_reg;

    logic [ENT_W-1:0]     pend_mem [PENDING_DEPTH];
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 mem_rd_en, mem_wr_en;
    logic [IW-1:0]        ins_idx;
    logic                 ins_ok;
    logic                 out_load;

    logic [W-1:0]         r_eff;
    logic [ADDR_BITS-1:0] rd_start;
    logic [SZ-1:0]        rd_bytes;
    logic [W-1:0]         sum_tmp;
    logic [W-1:0]         sub_tmp;
    logic [W-1:0]         space_tmp;
    logic [FIELDS_W-1:0]  out_fields;

    assign rd_start = rd_data_reg[ADDR_BITS-1:0];
    assign rd_bytes = rd_data_reg[ENT_W-1:ADDR_BITS];

    // effective region: clamp to [1, 2^ADDR_BITS]
    always_comb
    begin
        if (region_reg == '0)
            r_eff = W'(1);
        else if (region_reg[ADDR_BITS] && (|region_reg[ADDR_BITS-1:0]))
            r_eff = W'(1) << ADDR_BITS;
        else
            r_eff = W'(region_reg);
    end

    // lowest free pending slot
    always_comb
    begin
        ins_idx = '0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                ins_idx = IW'(i);
        end
        ins_ok = ~&valid_reg;
    end

    assign s_axis_tready = (state_reg == rba_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_load      = (state_reg == rba_pkg::S_DONE) &&
                           (!out_valid_reg || m_axis_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rba_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (in_op)
                        rba_pkg::OP_ALLOC: state_next = rba_pkg::S_AL_ROUND;
                        rba_pkg::OP_FREE:  state_next = rba_pkg::S_OLD_A;
                        default:           state_next = rba_pkg::S_DONE;
                    endcase
                end
            end
            rba_pkg::S_AL_ROUND: state_next = rba_pkg::S_AL_SUM;
            rba_pkg::S_AL_SUM:   state_next = rba_pkg::S_AL_CHECK;
            rba_pkg::S_AL_CHECK:
            begin
                if (used_reg + inc_reg > r_eff)
                    state_next = rba_pkg::S_DONE;
                else if (!wrapped_reg && (end_reg > r_eff))
                    state_next = rba_pkg::S_AL_WRAP;
                else
                    state_next = rba_pkg::S_AL_COMMIT;
            end
            rba_pkg::S_AL_WRAP:   state_next = rba_pkg::S_AL_WRAP2;
            rba_pkg::S_AL_WRAP2:  state_next = rba_pkg::S_AL_CHECK;
            rba_pkg::S_AL_COMMIT: state_next = rba_pkg::S_DONE;
            rba_pkg::S_OLD_A:     state_next = rba_pkg::S_OLD_B;
            rba_pkg::S_OLD_B:
                state_next = head_reg ? rba_pkg::S_HEAD : rba_pkg::S_SCAN_RD;
            rba_pkg::S_HEAD:      state_next = rba_pkg::S_OLD_A;
            rba_pkg::S_SCAN_RD:
            begin
                if (valid_reg[idx_reg])
                    state_next = rba_pkg::S_SCAN_CMP;
                else if (idx_reg == LAST_IDX)
                    state_next = rba_pkg::S_DONE;
            end
            rba_pkg::S_SCAN_CMP:
            begin
                if (W'(rd_start) == actual_reg)
                    state_next = rba_pkg::S_OLD_A;
                else if (idx_reg == LAST_IDX)
                    state_next = rba_pkg::S_DONE;
                else
                    state_next = rba_pkg::S_SCAN_RD;
            end
            rba_pkg::S_DONE:
            begin
                if (out_load)
                    state_next = rba_pkg::S_IDLE;
            end
            default: state_next = rba_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        req_next      = req_reg;
        foff_next     = foff_reg;
        fsize_next    = fsize_reg;
        wo_next       = wo_reg;
        used_next     = used_reg;
        eskip_next    = eskip_reg;
        wp_next       = wp_reg;
        bytes_next    = bytes_reg;
        inc_next      = inc_reg;
        end_next      = end_reg;
        wrapped_next  = wrapped_reg;
        internal_next = internal_reg;
        actual_next   = actual_reg;
        skip_next     = skip_reg;
        skipd_next    = skipd_reg;
        head_next     = head_reg;
        status_next   = status_reg;
        res_off_next  = res_off_reg;
        res_size_next = res_size_reg;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        mem_rd_en     = 1'b0;
        mem_wr_en     = 1'b0;
        sum_tmp       = '0;
        sub_tmp       = '0;
        case (state_reg)
            rba_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next      = in_req;
                    foff_next     = in_foff;
                    fsize_next    = in_fsize;
                    status_next   = rba_pkg::ST_OK;
                    res_off_next  = '0;
                    res_size_next = '0;
                    head_next     = 1'b1;
                    if (in_op == rba_pkg::OP_RESET)
                    begin
                        wo_next   = '0;
                        used_next = '0;
                    end
                end
            end
            rba_pkg::S_AL_ROUND:
            begin
                wp_next      = round_up(wo_reg, align_reg);
                bytes_next   = round_up(W'(req_reg), align_reg);
                wrapped_next = 1'b0;
            end
            rba_pkg::S_AL_SUM:
            begin
                end_next = wp_reg + bytes_reg;
                inc_next = wp_reg + bytes_reg - wo_reg;
            end
            rba_pkg::S_AL_CHECK:
            begin
                if (used_reg + inc_reg > r_eff)
                    status_next = rba_pkg::ST_NOSPACE;
            end
            rba_pkg::S_AL_WRAP:
            begin
                eskip_next = sat_sub(r_eff, wo_reg);
                wo_next    = '0;
            end
            rba_pkg::S_AL_WRAP2:
            begin
                used_next    = used_reg + eskip_reg;
                wp_next      = '0;
                inc_next     = bytes_reg;
                wrapped_next = 1'b1;
            end
            rba_pkg::S_AL_COMMIT:
            begin
                sum_tmp       = wo_reg + inc_reg;
                wo_next       = (sum_tmp > r_eff) ? '0 : sum_tmp;
                used_next     = used_reg + inc_reg;
                res_off_next  = wp_reg[ADDR_BITS-1:0];
                res_size_next = bytes_reg[SZ-1:0];
            end
            rba_pkg::S_OLD_A:
            begin
                if (used_reg > wo_reg)
                    internal_next = sat_sub(r_eff, used_reg - wo_reg);
                else
                    internal_next = wo_reg - used_reg;
            end
            rba_pkg::S_OLD_B:
            begin
                // a wrap skipped the tail: the oldest block really starts at 0
                if ((internal_reg + eskip_reg == r_eff) && (internal_reg != '0))
                begin
                    actual_next = '0;
                    skip_next   = sat_sub(r_eff, internal_reg);
                    skipd_next  = 1'b1;
                end
                else
                begin
                    actual_next = internal_reg;
                    skip_next   = '0;
                    skipd_next  = 1'b0;
                end
                idx_next = '0;
            end
            rba_pkg::S_HEAD:
            begin
                head_next = 1'b0;
                if (W'(foff_reg) == actual_reg)
                begin
                    sub_tmp   = W'(fsize_reg) + skip_reg;
                    used_next = sat_sub(used_reg, sub_tmp);
                    if (skipd_reg)
                        eskip_next = '0;
                end
                else if (ins_ok)
                begin
                    mem_wr_en           = 1'b1;
                    valid_next[ins_idx] = 1'b1;
                end
                else
                begin
                    status_next = rba_pkg::ST_FULL;
                end
            end
            rba_pkg::S_SCAN_RD:
            begin
                if (valid_reg[idx_reg])
                    mem_rd_en = 1'b1;
                else if (idx_reg != LAST_IDX)
                    idx_next = idx_reg + IW'(1);
            end
            rba_pkg::S_SCAN_CMP:
            begin
                if (W'(rd_start) == actual_reg)
                begin
                    sub_tmp             = W'(rd_bytes) + skip_reg;
                    used_next           = sat_sub(used_reg, sub_tmp);
                    valid_next[idx_reg] = 1'b0;
                    if (skipd_reg)
                        eskip_next = '0;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // response fields
    always_comb
    begin
        space_tmp  = sat_sub(r_eff, used_reg);
        out_fields = {space_tmp[SZ-1:0], res_size_reg, res_off_reg, status_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rba_pkg::S_IDLE;
            region_reg    <= {1'b1, {ADDR_BITS{1'b0}}};
            align_reg     <= rba_pkg::RBA_ALIGN_RESET;
            wo_reg        <= '0;
            used_reg      <= '0;
            eskip_reg     <= '0;
            valid_reg     <= '0;
            head_reg      <= 1'b0;
            wrapped_reg   <= 1'b0;
            skipd_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wo_reg      <= wo_next;
            used_reg    <= used_next;
            eskip_reg   <= eskip_next;
            valid_reg   <= valid_next;
            head_reg    <= head_next;
            wrapped_reg <= wrapped_next;
            skipd_reg   <= skipd_next;
            idx_reg     <= idx_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    rba_pkg::CFG_REGION: region_reg <= cfg_wdata;
                    rba_pkg::CFG_ALIGN:  align_reg  <= cfg_wdata[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        foff_reg     <= foff_next;
        fsize_reg    <= fsize_next;
        wp_reg       <= wp_next;
        bytes_reg    <= bytes_next;
        inc_reg      <= inc_next;
        end_reg      <= end_next;
        internal_reg <= internal_next;
        actual_reg   <= actual_next;
        skip_reg     <= skip_next;
        status_reg   <= status_next;
        res_off_reg  <= res_off_next;
        res_size_reg <= res_size_next;
        if (out_load)
            out_data_reg <= DATA_W'(out_fields);
    end

    // pending table memory
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            pend_mem[ins_idx] <= {fsize_reg, foff_reg};
        if (mem_rd_en)
            rd_data_reg <= pend_mem[idx_reg];
    end

`ifndef SYNTHESIS
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rba_pkg::S_DONE)
        else $error("response raised outside the final state");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rba_pkg::S_SCAN_CMP |-> $past(mem_rd_en))
        else $error("pending compare without a preceding read");

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rba_pkg::S_IDLE |=> valid_reg == $past(valid_reg))
        else $error("pending table changed while idle");
`endif

endmodule
